[hw/rtl/kab_pkg.sv]
package kab_pkg;

  localparam int NUM_AXES = 3;
  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  localparam int VAL_W = 32;
  localparam int COV_W = 48;
  localparam int AX_W = 2;
  localparam int CFG_AW = 4;
  localparam int NUM_W = COV_W + 1;
  localparam int DEN_W = COV_W + 2;
  localparam int MUL_W = 64;
  localparam int EXT_W = 66;
  localparam int DIV_STEPS = NUM_W + 32;
  localparam int NUM_OPS = 6;

  localparam logic [1:0] REG_PNA = 2'd0;
  localparam logic [1:0] REG_PNB = 2'd1;
  localparam logic [1:0] REG_MN = 2'd2;

  localparam logic [31:0] PNA_RST = 32'd4294967;
  localparam logic [31:0] PNB_RST = 32'd42950;
  localparam logic [31:0] MN_RST = 32'd42949673;
  localparam logic signed [COV_W-1:0] COV_ONE = 48'sh0001_0000_0000;
  localparam logic [COV_W-2:0] GAIN_MAX = '1;

  localparam logic signed [EXT_W-1:0] C48_HI = 66'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [EXT_W-1:0] C48_LO = -66'sh0_8000_0000_0000;
  localparam logic signed [EXT_W-1:0] C32_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [EXT_W-1:0] C32_LO = -66'sh0_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SUMS, ST_GO, ST_DIV, ST_MUL, ST_UPD, ST_DONE
  } kab_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num0;
    logic signed [NUM_W-1:0] num1;
    logic [DEN_W-1:0]        den;
  } kab_div_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } kab_mul_req_t;

  function automatic logic signed [COV_W-1:0] sat48(input logic signed [EXT_W-1:0] v);
    if (v > C48_HI) return C48_HI[COV_W-1:0];
    if (v < C48_LO) return C48_LO[COV_W-1:0];
    return v[COV_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
    if (v > C32_HI) return C32_HI[VAL_W-1:0];
    if (v < C32_LO) return C32_LO[VAL_W-1:0];
    return v[VAL_W-1:0];
  endfunction

endpackage

[hw/rtl/kab_if.sv]
interface kab_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [31:0]          measured;
  logic [1:0]                  axis_sel;
  modport source (output valid, measured, axis_sel, input ready);
  modport sink (input valid, measured, axis_sel, output ready);
endinterface

interface kab_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  axis_out;
  logic signed [31:0]          accel_estimate;
  logic signed [31:0]          bias_estimate;
  modport source (output valid, axis_out, accel_estimate, bias_estimate, input ready);
  modport sink (input valid, axis_out, accel_estimate, bias_estimate, output ready);
endinterface

[hw/rtl/kab_div.sv]
module kab_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kab_pkg::kab_div_req_t            req,
  output logic                             done,
  output logic signed [kab_pkg::COV_W-1:0] k0,
  output logic signed [kab_pkg::COV_W-1:0] k1
);
  import kab_pkg::*;

  localparam int SH_W = NUM_W + 32;
  localparam int CW = $clog2(DIV_STEPS);

  logic [SH_W-1:0]   sh0_r, sh1_r;
  logic [DEN_W-1:0]  rem0_r, rem1_r, den_r;
  logic [COV_W-2:0]  q0_r, q1_r;
  logic              ov0_r, ov1_r, neg0_r, neg1_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, fin_r, done_r;
  logic [DEN_W:0]    t0, t1;
  logic              b0, b1;
  logic [NUM_W-1:0]  un0, un1;
  logic [COV_W-2:0]  m0, m1;

  assign un0 = req.num0[NUM_W-1] ? NUM_W'(-req.num0) : NUM_W'(req.num0);
  assign un1 = req.num1[NUM_W-1] ? NUM_W'(-req.num1) : NUM_W'(req.num1);
  assign t0 = {rem0_r, sh0_r[SH_W-1]};
  assign t1 = {rem1_r, sh1_r[SH_W-1]};
  assign b0 = (t0 >= {1'b0, den_r});
  assign b1 = (t1 >= {1'b0, den_r});
  assign m0 = ov0_r ? GAIN_MAX : q0_r;
  assign m1 = ov1_r ? GAIN_MAX : q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_STEPS - 1);
        sh0_r  <= {un0, 32'd0};
        sh1_r  <= {un1, 32'd0};
        neg0_r <= req.num0[NUM_W-1];
        neg1_r <= req.num1[NUM_W-1];
        den_r  <= req.den;
        rem0_r <= '0;
        rem1_r <= '0;
        q0_r   <= '0;
        q1_r   <= '0;
        ov0_r  <= 1'b0;
        ov1_r  <= 1'b0;
      end else if (busy_r) begin
        rem0_r <= b0 ? DEN_W'(t0 - {1'b0, den_r}) : t0[DEN_W-1:0];
        rem1_r <= b1 ? DEN_W'(t1 - {1'b0, den_r}) : t1[DEN_W-1:0];
        q0_r   <= {q0_r[COV_W-3:0], b0};
        q1_r   <= {q1_r[COV_W-3:0], b1};
        ov0_r  <= ov0_r | q0_r[COV_W-2];
        ov1_r  <= ov1_r | q1_r[COV_W-2];
        sh0_r  <= {sh0_r[SH_W-2:0], 1'b0};
        sh1_r  <= {sh1_r[SH_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
      if (fin_r) begin
        k0 <= neg0_r ? -$signed({1'b0, m0}) : $signed({1'b0, m0});
        k1 <= neg1_r ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
      end
    end
  end

  assign done = done_r;

endmodule

[hw/rtl/kab_mul.sv]
module kab_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kab_pkg::kab_mul_req_t            req,
  output logic                             done,
  output logic signed [kab_pkg::MUL_W-1:0] p
);
  import kab_pkg::*;

  logic [MUL_W-1:0]   ma_r, mb_r, pp_r;
  logic               neg_r, busy_r, pv_r, done_r;
  logic [2:0]         step_r;
  logic [1:0]         sh_r;
  logic [127:0]       acc_r, pp_sh;
  logic [31:0]        ha, hb;
  logic [95:0]        mag;
  logic [62:0]        cap;
  logic               over;

  assign ha = step_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign hb = step_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign mag = acc_r[127:32];
  assign over = (mag[95:63] != '0) || (mag[62] && (mag[61:0] != '0));
  assign cap = over ? {1'b1, 62'd0} : mag[62:0];

  always_comb begin
    case (sh_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      2'd2:    pp_sh = {pp_r, 64'd0};
      default: pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
        step_r <= '0;
        acc_r  <= '0;
        ma_r   <= req.a[MUL_W-1] ? -req.a : req.a;
        mb_r   <= req.b[MUL_W-1] ? -req.b : req.b;
        neg_r  <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          pp_r   <= ha * hb;
          sh_r   <= 2'(step_r[1]) + 2'(step_r[0]);
          pv_r   <= 1'b1;
          step_r <= step_r + 1'b1;
        end else begin
          pv_r <= 1'b0;
        end
        if (pv_r) begin
          acc_r <= acc_r + pp_sh;
        end
        if (step_r == 3'd4 && !pv_r) begin
          p      <= neg_r ? -$signed({1'b0, cap}) : $signed({1'b0, cap});
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;

endmodule

[hw/rtl/two_state_kalman_accel_bias.sv]
// Channel | Dir | Handshake    | Word
// in_ch   | in  | valid/ready  | measured (s32 Q16.16), axis_sel (2)
// out_ch  | out | valid/ready  | axis_out (2), accel_estimate, bias_estimate (s32 Q16.16)
// cfg     | in  | APB          | 0 process_noise_accel, 1 process_noise_bias,
//         |     |              | 2 measurement_noise (u32 Q0.32)
// An in-range sample runs from one accepted word to the next through LOAD, SUMS and GO to
// load and sum, the serial divider (81 steps, both gains at once), six products (four
// passes each on the shared 32x32 multiplier), then UPD to update, DONE to load the output
// register, and back to IDLE; the result shows once the output register is loaded.
// A sample with S <= 0 skips the divider; an axis out of range goes straight to DONE.
// Reset is synchronous, active low, and restores registers, estimates and covariances.
// in_ch.ready stays low while a sample is at work; a stalled result holds in the
// output register and the next sample is taken meanwhile.
module two_state_kalman_accel_bias (
  input  logic                        clk,
  input  logic                        rst_n,
  kab_in_if.sink                      in_ch,
  kab_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kab_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import kab_pkg::*;

  kab_state_t state_r, state_nxt;

  logic [31:0] pna_r, pnb_r, mn_r;

  logic signed [VAL_W-1:0] est_a_r [NUM_AXES];
  logic signed [VAL_W-1:0] est_b_r [NUM_AXES];
  logic signed [COV_W-1:0] caa_r [NUM_AXES];
  logic signed [COV_W-1:0] cab_r [NUM_AXES];
  logic signed [COV_W-1:0] cba_r [NUM_AXES];
  logic signed [COV_W-1:0] cbb_r [NUM_AXES];

  logic signed [VAL_W-1:0] z_r;
  logic [AX_W-1:0]         ax_r;
  logic signed [COV_W-1:0] paa_r, pab_r, pba_r, pbb_r, k0_r, k1_r;
  logic signed [VAL_W+1:0] y_r;
  logic signed [NUM_W-1:0] n0_r, n1_r, ca_r, cb_r;
  logic signed [DEN_W:0]   s_r;
  logic signed [MUL_W-1:0] m_r [NUM_OPS];
  logic [2:0]              op_r;
  logic                    iss_r;
  logic signed [VAL_W-1:0] res_a_r, res_b_r;

  logic                    out_valid_r;
  logic [AX_W-1:0]         out_ax_r;
  logic signed [VAL_W-1:0] out_a_r, out_b_r;

  logic [AXW-1:0]          idx;
  logic                    in_acc, in_bad, out_load, cfg_wr;
  kab_div_req_t            div_req;
  kab_mul_req_t            mul_req;
  logic                    div_done, mul_done;
  logic signed [COV_W-1:0] div_k0, div_k1;
  logic signed [MUL_W-1:0] mul_p;
  logic signed [MUL_W-1:0] op_a, op_b;

  assign idx = ax_r[AXW-1:0];
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_bad = int'(in_ch.axis_sel) >= NUM_AXES;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_PNA: prdata = pna_r;
      REG_PNB: prdata = pnb_r;
      REG_MN:  prdata = mn_r;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pna_r <= PNA_RST;
      pnb_r <= PNB_RST;
      mn_r  <= MN_RST;
    end else if (cfg_wr) begin
      case (paddr[CFG_AW-1:2])
        REG_PNA: pna_r <= pwdata;
        REG_PNB: pnb_r <= pwdata;
        REG_MN:  mn_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (op_r)
      3'd0:    begin op_a = MUL_W'(k0_r); op_b = MUL_W'(y_r);  end
      3'd1:    begin op_a = MUL_W'(k1_r); op_b = MUL_W'(y_r);  end
      3'd2:    begin op_a = MUL_W'(k0_r); op_b = MUL_W'(ca_r); end
      3'd3:    begin op_a = MUL_W'(k0_r); op_b = MUL_W'(cb_r); end
      3'd4:    begin op_a = MUL_W'(k1_r); op_b = MUL_W'(ca_r); end
      3'd5:    begin op_a = MUL_W'(k1_r); op_b = MUL_W'(cb_r); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = in_bad ? ST_DONE : ST_LOAD;
      ST_LOAD: state_nxt = ST_SUMS;
      ST_SUMS: state_nxt = ST_GO;
      ST_GO:   state_nxt = (s_r > 0) ? ST_DIV : ST_MUL;
      ST_DIV:  if (div_done) state_nxt = ST_MUL;
      ST_MUL:  if (mul_done && op_r == 3'(NUM_OPS - 1)) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = 1'b0;
    out_load      = 1'b0;
    div_req.start = 1'b0;
    mul_req.start = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_GO:   div_req.start = (s_r > 0);
      ST_MUL:  mul_req.start = !iss_r;
      ST_DONE: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign div_req.num0 = n0_r;
  assign div_req.num1 = n1_r;
  assign div_req.den = s_r[DEN_W-1:0];
  assign mul_req.a = op_a;
  assign mul_req.b = op_b;

  kab_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .k0   (div_k0),
    .k1   (div_k1)
  );

  kab_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .p    (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iss_r   <= 1'b0;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_req.start) iss_r <= 1'b1;
      if (mul_done) begin
        iss_r <= 1'b0;
        op_r  <= (op_r == 3'(NUM_OPS - 1)) ? 3'd0 : op_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      z_r     <= in_ch.measured;
      ax_r    <= in_ch.axis_sel;
      res_a_r <= '0;
      res_b_r <= '0;
    end
    if (state_r == ST_LOAD) begin
      paa_r <= sat48(EXT_W'(caa_r[idx]) + $signed({34'd0, pna_r}));
      pab_r <= cab_r[idx];
      pba_r <= cba_r[idx];
      pbb_r <= sat48(EXT_W'(cbb_r[idx]) + $signed({34'd0, pnb_r}));
      y_r   <= (VAL_W+2)'(z_r) - (VAL_W+2)'(est_a_r[idx]) - (VAL_W+2)'(est_b_r[idx]);
    end
    if (state_r == ST_SUMS) begin
      n0_r <= NUM_W'(paa_r) + NUM_W'(pab_r);
      n1_r <= NUM_W'(pba_r) + NUM_W'(pbb_r);
      ca_r <= NUM_W'(paa_r) + NUM_W'(pba_r);
      cb_r <= NUM_W'(pab_r) + NUM_W'(pbb_r);
      s_r  <= (DEN_W+1)'(paa_r) + (DEN_W+1)'(pab_r) + (DEN_W+1)'(pba_r)
            + (DEN_W+1)'(pbb_r) + $signed({19'd0, mn_r});
    end
    if (state_r == ST_GO) begin
      k0_r <= '0;
      k1_r <= '0;
    end
    if (div_done) begin
      k0_r <= div_k0;
      k1_r <= div_k1;
    end
    if (mul_done) m_r[op_r] <= mul_p;
    if (state_r == ST_UPD) begin
      res_a_r <= sat32(EXT_W'(est_a_r[idx]) + EXT_W'(m_r[0]));
      res_b_r <= sat32(EXT_W'(est_b_r[idx]) + EXT_W'(m_r[1]));
    end
    if (out_load) begin
      out_ax_r <= ax_r;
      out_a_r  <= res_a_r;
      out_b_r  <= res_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        est_a_r[i] <= '0;
        est_b_r[i] <= '0;
        caa_r[i]   <= COV_ONE;
        cab_r[i]   <= '0;
        cba_r[i]   <= '0;
        cbb_r[i]   <= COV_ONE;
      end
    end else if (state_r == ST_UPD) begin
      est_a_r[idx] <= sat32(EXT_W'(est_a_r[idx]) + EXT_W'(m_r[0]));
      est_b_r[idx] <= sat32(EXT_W'(est_b_r[idx]) + EXT_W'(m_r[1]));
      caa_r[idx]   <= sat48(EXT_W'(paa_r) - EXT_W'(m_r[2]));
      cab_r[idx]   <= sat48(EXT_W'(pab_r) - EXT_W'(m_r[3]));
      cba_r[idx]   <= sat48(EXT_W'(pba_r) - EXT_W'(m_r[4]));
      cbb_r[idx]   <= sat48(EXT_W'(pbb_r) - EXT_W'(m_r[5]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.axis_out = out_ax_r;
  assign out_ch.accel_estimate = out_a_r;
  assign out_ch.bias_estimate = out_b_r;

endmodule

[hw/rtl/kab_checker.sv]
module kab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  axis_out,
  input logic [31:0] accel_estimate,
  input logic [31:0] bias_estimate,
  input logic        pready
);
  import kab_pkg::*;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after a word was taken");

  a_bad_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (int'(axis_out) >= NUM_AXES) |-> accel_estimate == '0 && bias_estimate == '0)
    else $error("nonzero estimate for an absent axis");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind two_state_kalman_accel_bias kab_checker u_kab_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .axis_out      (out_ch.axis_out),
  .accel_estimate(out_ch.accel_estimate),
  .bias_estimate (out_ch.bias_estimate),
  .pready        (pready)
);
